/* design/inalu_pkg.sv */
// ----------------------------------------------------------------------------
// inalu_pkg: shared types and constants
// Operation codes, default data width and quotient bits per divider stage
// for the integer node function unit.
// ----------------------------------------------------------------------------
package inalu_pkg;

  // Default operand and result width.
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Width of the function gene field.
  localparam int GENE_WIDTH = 5;

  // Quotient bits resolved per divider pipeline stage.
  localparam int DIV_BITS_PER_STAGE = 2;

  // Operation selected by the low two bits of the gene.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

endpackage

/* design/integer_node_alu_protected_divide.sv */
// ----------------------------------------------------------------------------
// integer_node_alu_protected_divide
// Pipelined integer node function unit: add, subtract, multiply (low half)
// and protected signed division, selected by the function gene modulo 4.
// ----------------------------------------------------------------------------
// Usage: the unit takes one item per cycle and delivers one result per item,
// in order. Every item, whatever its operation, passes through the same
// (DATA_WIDTH+1)/2 + 2 register stages. The stages are one entry stage that
// forms operand magnitudes, add/sub results and three partial products, a
// radix-2 restoring divider that resolves two quotient bits per stage, and an
// output stage that applies the quotient sign. The latency is set by the
// divider chain; throughput is one transfer per cycle as long as the output
// side takes results. Each stage holds its item when the stage after it is
// full and stalled, so a stall on the output fills bubbles first and only
// then drops in_ready_o. A zero divisor returns operand_a; the most negative
// value over minus one wraps to itself; all other results wrap to DATA_WIDTH
// bits. Gene bits above the low two are ignored. The unit has no
// configuration and no state beyond the pipeline itself.
// ----------------------------------------------------------------------------
module integer_node_alu_protected_divide
  import inalu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [GENE_WIDTH-1:0]        req_type_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] node_value_o
);

  localparam int W     = DATA_WIDTH;
  localparam int R     = DIV_BITS_PER_STAGE;
  // Divider stages, each resolving R quotient bits.
  localparam int NSTEP = (W + R - 1) / R;
  // Entry stage, divider stages, output stage.
  localparam int NS    = NSTEP + 2;
  // Split point of the multiplier operands.
  localparam int H     = (W + 1) / 2;
  localparam int HI    = W - H;
  localparam logic [W-1:0] ONE = W'(1);

  // --------------------------------------------------------------------------
  // Stage flow control: a stage advances when it is empty or the next one
  // advances. The last stage advances when empty or the result is taken.
  // --------------------------------------------------------------------------
  logic [NS-1:0] valid_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Per-stage payload. Index 0 is the entry stage, 1..NSTEP the divider.
  // --------------------------------------------------------------------------
  op_e          op_q  [NSTEP+1];
  logic [W-1:0] res_q [NSTEP+1];  // add/sub/mul result, or operand a for div
  logic [W-1:0] rem_q [NSTEP+1];  // partial remainder
  logic [W-1:0] quo_q [NSTEP+1];  // dividend bits shifting out, quotient in
  logic [W-1:0] qb_q  [NSTEP+1];  // divisor magnitude
  logic         neg_q [NSTEP+1];  // quotient sign
  logic         bz_q  [NSTEP+1];  // divisor is zero

  // Multiplier partial products, entry stage only.
  logic [2*H-1:0] p0_q;
  logic [W-1:0]   p1_q;
  logic [W-1:0]   p2_q;

  // --------------------------------------------------------------------------
  // Entry stage: decode, add/sub, magnitudes, partial products.
  // --------------------------------------------------------------------------
  logic [W-1:0]   a_u;
  logic [W-1:0]   b_u;
  op_e            op_d;
  logic [W-1:0]   res_d;
  logic [W-1:0]   mag_a;
  logic [W-1:0]   mag_b;
  logic [2*H-1:0] p0_d;
  logic [W-1:0]   p1_d;
  logic [W-1:0]   p2_d;

  assign a_u  = W'(operand_a_i);
  assign b_u  = W'(operand_b_i);
  assign op_d = op_e'(req_type_i[1:0]);

  assign mag_a = a_u[W-1] ? (~a_u + ONE) : a_u;
  assign mag_b = b_u[W-1] ? (~b_u + ONE) : b_u;

  // Low W bits of a*b = lo*lo + ((lo*hi + hi*lo) << H).
  assign p0_d = {{(2*H-H){1'b0}}, a_u[H-1:0]} * {{(2*H-H){1'b0}}, b_u[H-1:0]};
  assign p1_d = {{(W-H){1'b0}}, a_u[H-1:0]} * {{(W-HI){1'b0}}, b_u[W-1:H]};
  assign p2_d = {{(W-HI){1'b0}}, a_u[W-1:H]} * {{(W-H){1'b0}}, b_u[H-1:0]};

  always_comb begin
    unique case (op_d)
      OP_ADD:  res_d = a_u + b_u;
      OP_SUB:  res_d = a_u - b_u;
      OP_MUL:  res_d = '0;          // filled in by the next stage
      OP_DIV:  res_d = a_u;         // zero divisor passes operand a
      default: res_d = a_u;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      op_q[0]  <= op_d;
      res_q[0] <= res_d;
      rem_q[0] <= '0;
      quo_q[0] <= mag_a;
      qb_q[0]  <= mag_b;
      neg_q[0] <= a_u[W-1] ^ b_u[W-1];
      bz_q[0]  <= (b_u == '0);
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      p2_q     <= p2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: R restoring steps each. The first one also sums the
  // multiplier partial products.
  // --------------------------------------------------------------------------
  logic [W-1:0] mul_sum;
  logic [W-1:0] mul_cross;

  assign mul_cross = p1_q + p2_q;
  assign mul_sum   = p0_q[W-1:0] + (mul_cross << H);

  for (genvar k = 1; k <= NSTEP; k++) begin : g_div
    logic [W-1:0] rem_d;
    logic [W-1:0] quo_d;
    logic [W-1:0] res_s;

    always_comb begin
      logic [W:0]   t;
      logic [W:0]   diff;
      t     = '0;
      diff  = '0;
      rem_d = rem_q[k-1];
      quo_d = quo_q[k-1];
      for (int r = 0; r < R; r++) begin
        // Skip the padding steps when W is not a multiple of R.
        if ((k - 1) * R + r < W) begin
          t    = {rem_d, quo_d[W-1]};
          diff = t - {1'b0, qb_q[k-1]};
          if (!diff[W]) begin
            rem_d = diff[W-1:0];
            quo_d = {quo_d[W-2:0], 1'b1};
          end else begin
            rem_d = t[W-1:0];
            quo_d = {quo_d[W-2:0], 1'b0};
          end
        end
      end
    end

    if (k == 1) begin : g_mul
      assign res_s = (op_q[0] == OP_MUL) ? mul_sum : res_q[0];
    end else begin : g_pass
      assign res_s = res_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && valid_q[k-1]) begin
        op_q[k]  <= op_q[k-1];
        res_q[k] <= res_s;
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        qb_q[k]  <= qb_q[k-1];
        neg_q[k] <= neg_q[k-1];
        bz_q[k]  <= bz_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign the quotient, pick the result, hold while stalled.
  // --------------------------------------------------------------------------
  logic [W-1:0] quo_f;
  logic [W-1:0] quo_s;
  logic [W-1:0] node_d;
  logic [W-1:0] node_q;

  assign quo_f  = quo_q[NSTEP];
  assign quo_s  = neg_q[NSTEP] ? (~quo_f + ONE) : quo_f;
  assign node_d = (op_q[NSTEP] == OP_DIV && !bz_q[NSTEP]) ? quo_s : res_q[NSTEP];

  always_ff @(posedge clk_i) begin
    if (adv[NS-1] && valid_q[NS-2]) begin
      node_q <= node_d;
    end
  end

  assign out_valid_o  = valid_q[NS-1];
  assign node_value_o = signed'(node_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Back-pressure reaches the input only once every stage is occupied.
  a_ready_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (valid_q == {NS{1'b1}})
  ) else $error("in_ready_o low while a pipeline stage is empty");

  // A transfer in lands in the entry stage.
  a_entry_loaded : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0]
  ) else $error("accepted item missing from entry stage");

  // A stalled result keeps its value.
  a_out_hold : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(node_value_o))
  ) else $error("stalled result changed or dropped");

endmodule
